// ----- rtl/qrdec_pkg.sv -----
// Package: shared constants, types and syndrome helpers for the QR(16,7,6) decoder.
`timescale 1ns / 1ps
package qrdec_pkg;

   localparam int unsigned CW_W      = 17;   // cyclic word width
   localparam int unsigned RX_W      = 16;   // received word width
   localparam int unsigned DATA_W    = 7;    // data bits
   localparam int unsigned CNT_W     = 5;    // error count / counter width
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned PARITY_POS = 15;

   localparam logic [8:0] GEN_POLY = 9'h139;

   // search bounds: rotations per pass, passes (base pass plus one per flipped bit)
   localparam logic [CNT_W-1:0] LAST_ROT  = CNT_W'(CW_W - 1);
   localparam logic [CNT_W-1:0] LAST_PASS = CNT_W'(CW_W);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PARITY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SYNDROME = 2'd2;

   // result of one trap step
   typedef struct packed {
      logic [CW_W-1:0]  syn;       // syndrome of the current word
      logic [CNT_W-1:0] weight;    // syndrome weight
      logic [CW_W-1:0]  cw_rotl;   // word rotated left by one
      logic [CW_W-1:0]  cw_fixed;  // (word ^ syndrome) rotated back
   } trap_type;

   // syndrome over a 17-bit word: seven divide steps, left-aligned to bit 7
   function automatic logic [CW_W-1:0] syn17(input logic [CW_W-1:0] x);
      logic [CW_W-1:0] v;
      v = x;
      for (int k = 0; k < DATA_W; k++) begin
         if (v[0]) begin
            v = v ^ CW_W'(GEN_POLY);
         end
         v = v >> 1;
      end
      return {v[CW_W-DATA_W-1:0], {DATA_W{1'b0}}};
   endfunction

   // population count of a 17-bit word
   function automatic logic [CNT_W-1:0] pop17(input logic [CW_W-1:0] x);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int k = 0; k < CW_W; k++) begin
         c = c + CNT_W'(x[k]);
      end
      return c;
   endfunction

endpackage

// ----- rtl/qrdec_req_if.sv -----
// Interface: request channel carrying one received word per transaction.
`timescale 1ns / 1ps
interface qrdec_req_if;
   logic                         valid;
   logic                         ready;
   logic [qrdec_pkg::RX_W-1:0]   received_word;

   modport source (output valid, output received_word, input ready);
   modport sink   (input valid, input received_word, output ready);
endinterface

// ----- rtl/qrdec_rsp_if.sv -----
// Interface: response channel carrying one decode result per transaction.
`timescale 1ns / 1ps
interface qrdec_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [qrdec_pkg::CW_W-1:0]        decoded_word;
   logic [qrdec_pkg::DATA_W-1:0]      data_bits;
   logic [qrdec_pkg::CNT_W-1:0]       error_count;
   logic [qrdec_pkg::STATUS_W-1:0]    status;

   modport source (output valid, output decoded_word, output data_bits,
                   output error_count, output status, input ready);
   modport sink   (input valid, input decoded_word, input data_bits,
                   input error_count, input status, output ready);
endinterface

// ----- rtl/qrdec_trap_unit.sv -----
// Shared trap unit: syndrome, weight, rotate and error-trap correction of one word.
`timescale 1ns / 1ps
module qrdec_trap_unit (
   input  logic [qrdec_pkg::CW_W-1:0]  cw,
   input  logic [qrdec_pkg::CNT_W-1:0] rot_cnt,
   output qrdec_pkg::trap_type         trap
);
   import qrdec_pkg::*;

   logic [CW_W-1:0]   syn;
   logic [CW_W-1:0]   fixed_pre;
   logic [2*CW_W-1:0] dbl;

   // syndrome and its weight
   assign syn = syn17(cw);

   // trapped error removed, then undo rot_cnt left rotations
   assign fixed_pre = cw ^ syn;
   assign dbl       = {fixed_pre, fixed_pre} >> rot_cnt;

   always_comb begin
      trap.syn      = syn;
      trap.weight   = pop17(syn);
      trap.cw_rotl  = {cw[CW_W-2:0], cw[CW_W-1]};
      trap.cw_fixed = dbl[CW_W-1:0];
   end

endmodule

// ----- rtl/qr_16_7_6_decoder_unit.sv -----
// Top level: QR(16,7,6) decoder with iterative rotate-and-trap search.
// Correct mode: response valid once the search after the request succeeds or is exhausted;
//   one rotation step per cycle through the shared trap unit, up to 18 passes of 17 steps.
// Detect mode: response valid in the cycle after the request transaction.
// Throughput: one word at a time; ready again the cycle after the response is taken.
// Reset (synchronous, active high): idle, no response pending, correct_ff = 1.
`timescale 1ns / 1ps
module qr_16_7_6_decoder_unit (
   input  logic                 clock,
   input  logic                 reset,
   qrdec_req_if.sink            req_ch,
   qrdec_rsp_if.source          rsp_ch,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);
   import qrdec_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   // control registers
   state_type         state_ff, state_in;
   logic              correct_ff;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic [CNT_W-1:0]  rot_ff, rot_in;

   // payload registers
   logic [CW_W-1:0]     saved_ff, saved_in;
   logic                pbit_ff, pbit_in;
   logic [CW_W-1:0]     cw_ff, cw_in;
   logic [CW_W-1:0]     mask_ff, mask_in;
   logic [CNT_W-1:0]    errs_ff, errs_in;
   logic [CW_W-1:0]     dec_ff, dec_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   trap_type          trap;
   logic [CNT_W-1:0]  limit;
   logic              finish;
   logic [CW_W-1:0]   result;
   logic [CW_W-1:0]   rx_strip;
   logic [CW_W-1:0]   rx_word;

   qrdec_trap_unit u_trap (
      .cw      (cw_ff),
      .rot_cnt (rot_ff),
      .trap    (trap)
   );

   assign rx_word  = CW_W'(req_ch.received_word);
   assign rx_strip = {2'b00, req_ch.received_word[PARITY_POS-1:0]};

   // handshake and response payload
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_DONE);
   assign rsp_ch.decoded_word = dec_ff;
   assign rsp_ch.data_bits    = dec_ff[DATA_W-1:0];
   assign rsp_ch.error_count  = errs_ff;
   assign rsp_ch.status       = status_ff;

   // accepted weight: two on the base pass, one on flip passes
   assign limit = (pass_ff == '0) ? CNT_W'(2) : CNT_W'(1);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      rot_in    = rot_ff;
      saved_in  = saved_ff;
      pbit_in   = pbit_ff;
      cw_in     = cw_ff;
      mask_in   = mask_ff;
      errs_in   = errs_ff;
      dec_in    = dec_ff;
      status_in = status_ff;
      finish    = 1'b0;
      result    = saved_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (correct_ff) begin
                  saved_in = rx_strip;
                  pbit_in  = req_ch.received_word[PARITY_POS];
                  cw_in    = rx_strip;
                  mask_in  = CW_W'(1);
                  pass_in  = '0;
                  rot_in   = '0;
                  errs_in  = '0;
                  state_in = ST_SEARCH;
               end else begin
                  dec_in = rx_word;
                  if (^req_ch.received_word) begin
                     errs_in   = CNT_W'(1);
                     status_in = STATUS_PARITY;
                  end else if (syn17(rx_strip) != '0) begin
                     errs_in   = CNT_W'(1);
                     status_in = STATUS_SYNDROME;
                  end else begin
                     errs_in   = '0;
                     status_in = STATUS_OK;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         ST_SEARCH: begin
            if ((rot_ff == '0) && (trap.syn == '0)) begin
               // clean word at pass start: taken as it stands
               finish = 1'b1;
               result = cw_ff;
            end else begin
               errs_in = trap.weight;
               if (trap.weight <= limit) begin
                  finish = 1'b1;
                  result = trap.cw_fixed;
                  errs_in = trap.weight + ((pass_ff != '0) ? CNT_W'(1) : CNT_W'(0));
               end else if (rot_ff == LAST_ROT) begin
                  if (pass_ff == LAST_PASS) begin
                     // search exhausted
                     finish = 1'b1;
                     result = saved_ff;
                  end else begin
                     // next pass flips the next bit
                     mask_in = (pass_ff == '0) ? CW_W'(1) : {mask_ff[CW_W-2:0], 1'b0};
                     cw_in   = saved_ff ^ mask_in;
                     pass_in = pass_ff + CNT_W'(1);
                     rot_in  = '0;
                  end
               end else begin
                  cw_in  = trap.cw_rotl;
                  rot_in = rot_ff + CNT_W'(1);
               end
            end
            if (finish) begin
               dec_in    = result | (CW_W'(pbit_ff) << PARITY_POS);
               status_in = (^dec_in) ? STATUS_PARITY : STATUS_OK;
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         correct_ff <= 1'b1;
         pass_ff    <= '0;
         rot_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         rot_ff   <= rot_in;
         if (csr_wr_en) begin
            correct_ff <= csr_wr_data;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      saved_ff  <= saved_in;
      pbit_ff   <= pbit_in;
      cw_ff     <= cw_in;
      mask_ff   <= mask_in;
      errs_ff   <= errs_in;
      dec_ff    <= dec_in;
      status_ff <= status_in;
   end

endmodule
